### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, masked while reset is held.
`define EABD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define EABD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/eabd_pkg.sv
// ----------------------------------------------------------------------------
// eabd_pkg
// Widths, reset values, register indexes and helpers of the deinterlacer.
// ----------------------------------------------------------------------------
package eabd_pkg;

    localparam int PIX_W      = 8;   // luma / chroma byte
    localparam int DIFF_W     = 8;   // difference of two halved lumas
    localparam int VAL_W      = 16;  // wrapping decision arithmetic
    localparam int SQ_SHIFT   = 12;
    localparam int SQ_W       = 2;   // (T-B)^2 >> 12 never exceeds 3
    localparam int EDGE_W     = 14;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(625);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(73);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_DETECT = CFG_IDX_W'(0),
        REG_JAGGIE_THR  = CFG_IDX_W'(1)
    } t_cfg_reg;

    // Candidate output bytes carried down the pipe next to the decision math.
    typedef struct packed {
        logic [PIX_W-1:0] avg_luma;
        logic [PIX_W-1:0] avg_chroma;
        logic [PIX_W-1:0] mid_luma;
        logic [PIX_W-1:0] mid_chroma;
        logic             line_end;
    } t_cand;

    // Round-up average of two bytes.
    function automatic logic [PIX_W-1:0] avg_up(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
        return sum[PIX_W:1];
    endfunction

endpackage

### src/eabd_if.sv
// ----------------------------------------------------------------------------
// eabd_if
// Valid/ready channels of the deinterlacer: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface eabd_in_if;
    import eabd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] top_luma;
    logic [PIX_W-1:0] top_chroma;
    logic [PIX_W-1:0] mid_luma;
    logic [PIX_W-1:0] mid_chroma;
    logic [PIX_W-1:0] bottom_luma;
    logic [PIX_W-1:0] bottom_chroma;
    logic             line_end;

    modport source(output valid, top_luma, top_chroma, mid_luma, mid_chroma,
                   bottom_luma, bottom_chroma, line_end, input ready);
    modport sink(input valid, top_luma, top_chroma, mid_luma, mid_chroma,
                 bottom_luma, bottom_chroma, line_end, output ready);
endinterface

interface eabd_out_if;
    import eabd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_luma;
    logic [PIX_W-1:0] out_chroma;
    logic             line_end_out;

    modport source(output valid, out_luma, out_chroma, line_end_out, input ready);
    modport sink(input valid, out_luma, out_chroma, line_end_out, output ready);
endinterface

interface eabd_cfg_if;
    import eabd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;

    modport source(output valid, reg_idx, wdata, input ready);
    modport sink(input valid, reg_idx, wdata, output ready);
endinterface

### src/edge_adaptive_bob_deinterlace_core.sv
// ----------------------------------------------------------------------------
// edge_adaptive_bob_deinterlace_core
// Edge-adaptive bob: per 4:2:2 pixel, replace the middle line's bytes with
// the top/bottom round-up average when the luma shape looks like a jaggy.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction carries
//  ---------+-----+-----------------------------------------------------------
//  i_pix    | in  | top/mid/bottom luma+chroma bytes, line_end
//  o_pix    | out | out_luma, out_chroma, line_end_out
//  i_cfg    | in  | reg_idx (0 edge_detect, 1 jaggie_threshold), wdata
//
//  One pixel per clock sustained while o_pix is not stalled. Four register
//  stages lie between an input transaction and o_pix.valid: diffs, 8x8
//  products, weight multiply, compare/select into the output register.
//  Each stage loads when it is empty or its content moves on, so a stall on
//  o_pix only backs up the pipe; nothing is dropped or repeated.
//  Synchronous active-low reset clears stage valids and reloads the two
//  config registers (625, 73). Config writes are always accepted.
// ----------------------------------------------------------------------------
module edge_adaptive_bob_deinterlace_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    eabd_in_if.sink    i_pix,
    eabd_out_if.source o_pix,
    eabd_cfg_if.sink   i_cfg
);
    import eabd_pkg::*;

    // ---------------- config registers ----------------
    logic [EDGE_W-1:0] r_edge;
    logic [THR_W-1:0]  r_thr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= EDGE_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg.valid) begin
            // only the low bits of each register survive; unknown indexes drop
            if (i_cfg.reg_idx == REG_EDGE_DETECT) begin
                r_edge <= i_cfg.wdata[EDGE_W-1:0];
            end
            if (i_cfg.reg_idx == REG_JAGGIE_THR) begin
                r_thr <= i_cfg.wdata[THR_W-1:0];
            end
        end
    end

    // ---------------- stage flow control ----------------
    // r_vld[k] flags stage k+1. adv[k]: stage k+1 may load this cycle.
    logic [3:0] r_vld;
    logic [3:0] adv;

    assign adv[3] = !r_vld[3] || o_pix.ready;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];

    assign i_pix.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_pix.valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // ---------------- stage 1: halved lumas, differences ----------------
    // Halved lumas fit 7 bits, so 8-bit signed differences are exact and
    // sign-extend to the wrapped 16-bit values.
    logic [DIFF_W-1:0]        n_t, n_m, n_b;
    logic signed [DIFF_W-1:0] r_d1, r_d2, r_dtb;
    t_cand                    n_cand1, r_cand1;

    always_comb begin
        n_t = {1'b0, i_pix.top_luma[PIX_W-1:1]};
        n_m = {1'b0, i_pix.mid_luma[PIX_W-1:1]};
        n_b = {1'b0, i_pix.bottom_luma[PIX_W-1:1]};
        n_cand1.avg_luma   = avg_up(i_pix.top_luma, i_pix.bottom_luma);
        n_cand1.avg_chroma = avg_up(i_pix.top_chroma, i_pix.bottom_chroma);
        n_cand1.mid_luma   = i_pix.mid_luma;
        n_cand1.mid_chroma = i_pix.mid_chroma;
        n_cand1.line_end   = i_pix.line_end;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d1    <= $signed(n_t - n_m);
            r_d2    <= $signed(n_b - n_m);
            r_dtb   <= $signed(n_t - n_b);
            r_cand1 <= n_cand1;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [VAL_W-1:0] n_prod, r_prod2;
    logic signed [VAL_W-1:0] n_sqr;
    logic [SQ_W-1:0]         r_sq;
    t_cand                   r_cand2;

    always_comb begin
        n_prod = VAL_W'(r_d1) * VAL_W'(r_d2);
        n_sqr  = VAL_W'(r_dtb) * VAL_W'(r_dtb);   // at most 127^2, non-negative
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_prod2 <= n_prod;
            r_sq    <= n_sqr[SQ_SHIFT+SQ_W-1:SQ_SHIFT];
            r_cand2 <= r_cand1;
        end
    end

    // ---------------- stage 3: edge weighting ----------------
    logic [VAL_W-1:0]        n_weight, r_weight;
    logic signed [VAL_W-1:0] r_prod3;
    t_cand                   r_cand3;

    always_comb begin
        n_weight = VAL_W'({{(VAL_W-SQ_W){1'b0}}, r_sq} * {{(VAL_W-EDGE_W){1'b0}}, r_edge});
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_weight <= n_weight;
            r_prod3  <= r_prod2;
            r_cand3  <= r_cand2;
        end
    end

    // ---------------- stage 4: decide, select, output register ----------------
    logic [VAL_W-1:0] n_v;
    logic             n_repl;
    logic [PIX_W-1:0] r_luma, r_chroma;
    logic             r_le;

    always_comb begin
        n_v    = $unsigned(r_prod3) - r_weight;   // wraps mod 2^16
        n_repl = $signed(n_v) > $signed({{(VAL_W-THR_W){1'b0}}, r_thr});
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_luma   <= n_repl ? r_cand3.avg_luma   : r_cand3.mid_luma;
            r_chroma <= n_repl ? r_cand3.avg_chroma : r_cand3.mid_chroma;
            r_le     <= r_cand3.line_end;
        end
    end

    assign o_pix.valid        = r_vld[3];
    assign o_pix.out_luma     = r_luma;
    assign o_pix.out_chroma   = r_chroma;
    assign o_pix.line_end_out = r_le;

endmodule

### src/eabd_checker.sv
// ----------------------------------------------------------------------------
// eabd_checker
// Port-level checks of the deinterlacer, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eabd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [eabd_pkg::PIX_W-1:0] i_out_luma,
    input logic [eabd_pkg::PIX_W-1:0] i_out_chroma,
    input logic                       i_out_le,
    input logic                       i_cfg_ready
);
    logic w_out_free;
    assign w_out_free = !i_out_valid || i_out_ready;

    // pipe comes out of reset empty
    `EABD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // a stalled result holds
    `EABD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_luma) && $stable(i_out_chroma) && $stable(i_out_le), "stalled result changed")

    // a free output slot lets the whole pipe move, so input must be ready
    `EABD_ASSERT(a_in_ready, i_clk, i_rst_n, w_out_free |-> i_in_ready, "input stalled with free output")

    // configuration is never back-pressured
    `EABD_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_ready, "config port not ready")

endmodule

bind edge_adaptive_bob_deinterlace_core eabd_checker u_eabd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_out_luma   (o_pix.out_luma),
    .i_out_chroma (o_pix.out_chroma),
    .i_out_le     (o_pix.line_end_out),
    .i_cfg_ready  (i_cfg.ready)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge-adaptive bob deinterlacer core. Pixel
// trios go in over a valid/ready channel with random gaps. Each output
// transaction is compared with a software prediction of the jaggy decision
// and the top/bottom averaging, made with the register values in force. The
// output side stalls at random. Registers are rewritten only with the
// pipeline drained.
// ----------------------------------------------------------------------------
module testbench;
    import eabd_pkg::*;

    // Spare register indexes: writes to these must leave both registers alone.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HIGH = CFG_IDX_W'(255);

    localparam int QUIET_LIMIT = 5000;  // cycles with no transaction anywhere
    localparam int TAIL_CYCLES = 12;    // margin after the drain to catch stray outputs

    typedef struct packed {
        logic [PIX_W-1:0] top_luma;
        logic [PIX_W-1:0] top_chroma;
        logic [PIX_W-1:0] mid_luma;
        logic [PIX_W-1:0] mid_chroma;
        logic [PIX_W-1:0] bottom_luma;
        logic [PIX_W-1:0] bottom_chroma;
        logic             line_end;
    } pixel_trio_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma;
        logic             line_end;
    } pixel_out_t;

    logic i_clk;
    logic i_rst_n;

    eabd_in_if  pix_if();
    eabd_out_if out_if();
    eabd_cfg_if cfg_if();

    edge_adaptive_bob_deinterlace_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_pix   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copies of the two registers, as the DUT should hold them.
    logic [EDGE_W-1:0] edge_weight;
    logic [THR_W-1:0]  jaggy_thr;

    pixel_out_t expected_pixels[$];
    int         mismatch_count;

    // Random idling knobs; cleared to get back-to-back stretches.
    bit src_idles;
    bit sink_stalls;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] mean_up(logic [PIX_W-1:0] a,
                                                 logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = a + b + 1'b1;
        return sum[PIX_W:1];
    endfunction

    // All decision math wraps at 16 bits; v and the threshold compare signed.
    function automatic pixel_out_t deinterlace_pixel(pixel_trio_t p);
        logic [VAL_W-1:0] t, m, b;
        logic [VAL_W-1:0] d_tm, d_bm, shape, d_tb, sq, weighted, v;
        logic             take_avg;
        pixel_out_t       r;
        t        = VAL_W'(p.top_luma >> 1);
        m        = VAL_W'(p.mid_luma >> 1);
        b        = VAL_W'(p.bottom_luma >> 1);
        d_tm     = t - m;
        d_bm     = b - m;
        shape    = d_tm * d_bm;
        d_tb     = t - b;
        sq       = d_tb * d_tb;
        sq       = sq >> SQ_SHIFT;
        weighted = sq * VAL_W'(edge_weight);
        v        = shape - weighted;
        take_avg = $signed(v) > $signed(VAL_W'(jaggy_thr));
        // chroma follows the luma decision of the same pixel
        if (take_avg) begin
            r.luma   = mean_up(p.top_luma, p.bottom_luma);
            r.chroma = mean_up(p.top_chroma, p.bottom_chroma);
        end else begin
            r.luma   = p.mid_luma;
            r.chroma = p.mid_chroma;
        end
        r.line_end = p.line_end;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pixel_trio_t mk_pixel(int tl, int tc, int ml, int mc,
                                             int bl, int bc, bit le);
        pixel_trio_t p;
        p.top_luma      = PIX_W'(tl);
        p.top_chroma    = PIX_W'(tc);
        p.mid_luma      = PIX_W'(ml);
        p.mid_chroma    = PIX_W'(mc);
        p.bottom_luma   = PIX_W'(bl);
        p.bottom_chroma = PIX_W'(bc);
        p.line_end      = le;
        return p;
    endfunction

    function automatic int near_byte(int base, int spread);
        int x;
        x = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return x;
    endfunction

    function automatic int extreme_byte();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 254;
            default: return 255;
        endcase
    endfunction

    // Mix of plain noise, jaggy-looking trios, smooth areas and rail values.
    function automatic pixel_trio_t rand_pixel();
        int          kind, base;
        pixel_trio_t p;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 255);
        p.top_chroma    = PIX_W'($urandom);
        p.mid_chroma    = PIX_W'($urandom);
        p.bottom_chroma = PIX_W'($urandom);
        p.line_end      = ($urandom_range(0, 15) == 0);
        if (kind <= 3) begin
            p.top_luma    = PIX_W'($urandom);
            p.mid_luma    = PIX_W'($urandom);
            p.bottom_luma = PIX_W'($urandom);
        end else if (kind <= 6) begin
            // top and bottom agree, middle sticks out
            p.top_luma    = PIX_W'(near_byte(base, 12));
            p.bottom_luma = PIX_W'(near_byte(base, 12));
            p.mid_luma    = PIX_W'(near_byte(255 - base, 60));
        end else if (kind <= 8) begin
            p.top_luma    = PIX_W'(near_byte(base, 6));
            p.mid_luma    = PIX_W'(near_byte(base, 6));
            p.bottom_luma = PIX_W'(near_byte(base, 6));
        end else begin
            p.top_luma    = PIX_W'(extreme_byte());
            p.mid_luma    = PIX_W'(extreme_byte());
            p.bottom_luma = PIX_W'(extreme_byte());
        end
        return p;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // One input transaction. valid is left high on exit so that back-to-back
    // items never lower and raise it within one time step.
    task automatic send_pixel(pixel_trio_t p);
        int gap;
        gap = idle_len(src_idles);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.top_luma      <= p.top_luma;
        pix_if.top_chroma    <= p.top_chroma;
        pix_if.mid_luma      <= p.mid_luma;
        pix_if.mid_chroma    <= p.mid_chroma;
        pix_if.bottom_luma   <= p.bottom_luma;
        pix_if.bottom_chroma <= p.bottom_chroma;
        pix_if.line_end      <= p.line_end;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        expected_pixels.push_back(deinterlace_pixel(p));
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic drain_pipe();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Only called with the pipe drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid   <= 1'b1;
        cfg_if.reg_idx <= idx;
        cfg_if.wdata   <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == REG_EDGE_DETECT) edge_weight = data[EDGE_W-1:0];
        else if (idx == REG_JAGGIE_THR) jaggy_thr = data[THR_W-1:0];
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program both registers; random junk above the register width.
    task automatic set_regs(int edge_val, int thr_val);
        logic [CFG_DATA_W-1:0] junk;
        drain_pipe();
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_EDGE_DETECT, {junk[CFG_DATA_W-1:EDGE_W], EDGE_W'(edge_val)});
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_JAGGIE_THR, {junk[CFG_DATA_W-1:THR_W], THR_W'(thr_val)});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values in force: obvious jaggies, a hard edge, line end both ways.
    task automatic test_reset_defaults();
        send_pixel(mk_pixel(255, 10, 0, 200, 255, 30, 1'b0));   // dark line
        send_pixel(mk_pixel(0, 250, 255, 5, 0, 240, 1'b1));     // bright line
        send_pixel(mk_pixel(255, 0, 0, 255, 0, 0, 1'b0));       // vertical edge
        send_pixel(mk_pixel(100, 90, 100, 91, 100, 92, 1'b1));  // flat, no change
        send_pixel(mk_pixel(120, 0, 40, 255, 130, 255, 1'b0));  // darker middle, replaced
    endtask

    // Rails of every byte, odd/even luma pairs for the halving and rounding.
    task automatic test_field_extremes();
        send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 1'b0));
        send_pixel(mk_pixel(255, 255, 255, 255, 255, 255, 1'b1));
        send_pixel(mk_pixel(254, 255, 0, 0, 255, 0, 1'b0));    // odd average sum
        send_pixel(mk_pixel(1, 1, 255, 0, 0, 0, 1'b1));
        send_pixel(mk_pixel(0, 255, 128, 128, 255, 0, 1'b0));  // chroma swings
        send_pixel(mk_pixel(255, 0, 1, 255, 254, 255, 1'b1));
        send_pixel(mk_pixel(170, 85, 85, 170, 170, 85, 1'b0));
        send_pixel(mk_pixel(85, 170, 170, 85, 85, 170, 1'b1));
    endtask

    // Spare indexes must be ignored; over-wide data is cut to the register.
    // Full edge weight makes the subtracted term wrap into a positive v.
    task automatic test_register_writes();
        drain_pipe();
        write_reg(IDX_SPARE_LOW, 16'h0000);
        write_reg(IDX_SPARE_HIGH, 16'hFFFF);
        send_pixel(mk_pixel(255, 40, 0, 60, 255, 80, 1'b0));    // still defaults
        drain_pipe();
        write_reg(REG_EDGE_DETECT, 16'hFFFF);
        write_reg(REG_JAGGIE_THR, 16'hFFFF);
        send_pixel(mk_pixel(255, 10, 0, 20, 0, 30, 1'b0));      // wraps, replaces
        send_pixel(mk_pixel(0, 10, 255, 20, 255, 30, 1'b1));
        send_pixel(mk_pixel(255, 0, 0, 0, 255, 0, 1'b0));
        drain_pipe();
        write_reg(REG_EDGE_DETECT, 16'hC000);                   // weight 0
        write_reg(REG_JAGGIE_THR, 16'hE000);                    // threshold 0
        send_pixel(mk_pixel(255, 1, 0, 2, 0, 3, 1'b1));
        send_pixel(mk_pixel(4, 200, 2, 100, 4, 50, 1'b0));      // v = 1
        send_pixel(mk_pixel(2, 200, 2, 100, 2, 50, 1'b1));      // v = 0
    endtask

    // Corners and inner points of the register space, each with random pixels.
    task automatic test_config_sweep();
        int edges[7] = '{0, 16383, 10000, 0, 16383, 1, 625};
        int thrs[7]  = '{0, 8191, 5000, 8191, 0, 1, 73};
        for (int s = 0; s < 7; s++) begin
            set_regs(edges[s], thrs[s]);
            for (int k = 0; k < 20; k++) send_pixel(rand_pixel());
        end
    endtask

    // Long random stream: new register values now and then, an occasional
    // full drain, and idling switched on and off per stretch.
    task automatic test_random_traffic();
        for (int n = 0; n < 1380; n++) begin
            if (n % 60 == 0) begin
                src_idles   = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            if (n % 150 == 0) begin
                if ($urandom_range(0, 1) == 0)
                    set_regs($urandom_range(0, 10000), $urandom_range(0, 5000));
                else
                    set_regs($urandom_range(0, 16383), $urandom_range(0, 8191));
            end else if ($urandom_range(0, 199) == 0) begin
                drain_pipe();
            end
            send_pixel(rand_pixel());
        end
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure
    // ------------------------------------------------------------------------
    initial begin : sink_ready
        int stall_left;
        stall_left   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!sink_stalls || $urandom_range(0, 99) < 75) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 2);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pixel_out_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_pixels.size() == 0) begin
                $error("output transaction with nothing expected: luma %0h chroma %0h",
                       out_if.out_luma, out_if.out_chroma);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_if.out_luma !== want.luma) begin
                    $error("out_luma mismatch: expected %0h, actual %0h",
                           want.luma, out_if.out_luma);
                    mismatch_count++;
                end
                if (out_if.out_chroma !== want.chroma) begin
                    $error("out_chroma mismatch: expected %0h, actual %0h",
                           want.chroma, out_if.out_chroma);
                    mismatch_count++;
                end
                if (out_if.line_end_out !== want.line_end) begin
                    $error("line_end_out mismatch: expected %0b, actual %0b",
                           want.line_end, out_if.line_end_out);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("edge_adaptive_bob_deinterlace_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        edge_weight    = EDGE_RESET;
        jaggy_thr      = THR_RESET;
        src_idles      = 1'b1;
        sink_stalls    = 1'b1;

        i_rst_n              <= 1'b0;
        pix_if.valid         <= 1'b0;
        pix_if.top_luma      <= '0;
        pix_if.top_chroma    <= '0;
        pix_if.mid_luma      <= '0;
        pix_if.mid_chroma    <= '0;
        pix_if.bottom_luma   <= '0;
        pix_if.bottom_chroma <= '0;
        pix_if.line_end      <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.reg_idx       <= '0;
        cfg_if.wdata         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_register_writes();
        test_config_sweep();
        test_random_traffic();

        // let the pipe empty, then wait TAIL_CYCLES to catch stray outputs
        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("edge_adaptive_bob_deinterlace_core test passed");
        else
            $display("edge_adaptive_bob_deinterlace_core test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/eabd_pkg.sv
src/eabd_if.sv
src/edge_adaptive_bob_deinterlace_core.sv
src/eabd_checker.sv
dv/testbench.sv
